/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Every check is clocked on i_clk and is held off
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/psyx_pkg.sv */
// ----------------------------------------------------------------------------
// psyx_pkg
// Shared types, sizes and the ordering function of the point sorter.
// ----------------------------------------------------------------------------
package psyx_pkg;

    // Capacity of the cell chain, in points.
    localparam int MAX_POINTS = 64;
    // Width of one coordinate.
    localparam int COORD_W = 20;

    // One stored point.
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic load;   // insert the broadcast point into the chain
        logic shift;  // move every point one cell toward the head
    } t_cell_ctrl;

    // True when point a must come strictly before point b: by y, then by x.
    function automatic logic point_before(input t_point a, input t_point b);
        logic y_lt;
        logic y_eq;
        logic x_lt;
        y_lt = (a.y < b.y);
        y_eq = (a.y == b.y);
        x_lt = (a.x < b.x);
        return y_lt || (y_eq && x_lt);
    endfunction

endpackage

/* rtl/psyx_cell.sv */
// ----------------------------------------------------------------------------
// psyx_cell
// One cell of the insertion-sort chain. It holds one point and a valid bit.
// On a load it keeps its point, takes the broadcast point, or takes the
// point of its lower neighbor; on a shift it takes its upper neighbor's.
// ----------------------------------------------------------------------------
module psyx_cell
    import psyx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_point     i_point,       // point being inserted
    input  logic       i_prev_gt,     // lower neighbor lies after the new point
    input  t_point     i_prev_point,
    input  logic       i_prev_valid,
    input  t_point     i_next_point,
    input  logic       i_next_valid,
    output logic       o_gt,
    output t_point     o_point,
    output logic       o_valid
);

    t_point r_point;
    logic   r_valid;

    // The new point belongs at or below this cell when the cell is empty or
    // holds a point that sorts after it.
    assign o_gt = !r_valid || point_before(i_point, r_point);

    // Cell register: the valid bit is cleared by reset, the point is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_point <= i_next_point;
            r_valid <= i_next_valid;
        end else if (i_ctrl.load && o_gt) begin
            if (i_prev_gt) begin
                r_point <= i_prev_point;
                r_valid <= i_prev_valid;
            end else begin
                r_point <= i_point;
                r_valid <= 1'b1;
            end
        end
    end

    assign o_point = r_point;
    assign o_valid = r_valid;

endmodule

/* rtl/point_sort_by_y_then_x_core.sv */
// ----------------------------------------------------------------------------
// point_sort_by_y_then_x_core
// Sorts a set of signed 20-bit (x, y) points ascending by y, then by x,
// in a chain of insertion cells, and streams the sorted set out.
// ----------------------------------------------------------------------------
// A set of N points is loaded at one point per cycle: each request is placed
// into its sorted position across the 64-cell chain in the cycle it is
// accepted. The request flagged with tlast starts the drain, during which the
// chain shifts toward its head and delivers one result per cycle that the
// output side is ready; no input request is taken until the last result has
// gone. The load relies on the single compare in each cell and the drain on
// the one-point shift toward the head.
// Points arriving while all cells are full are dropped and tuser reports it
// on every result of that set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module point_sort_by_y_then_x_core
    import psyx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input point stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [2*COORD_W-1:0]  i_s_tdata,   // [19:0] point_x, [39:20] point_y
    input  logic                  i_s_tlast,   // final_point
    // Sorted result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [2*COORD_W-1:0]  o_m_tdata,   // [19:0] sorted_x, [39:20] sorted_y
    output logic                  o_m_tlast,   // last_out
    output logic                  o_m_tuser    // overflowed
);

    logic       r_drain;
    logic       r_ovf;
    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_full;
    t_point     w_in_point;
    t_cell_ctrl w_ctrl;

    logic   w_gt    [MAX_POINTS];
    logic   w_valid [MAX_POINTS];
    t_point w_point [MAX_POINTS];
    logic [MAX_POINTS-1:0] w_valid_vec;

    assign w_in_point = t_point'(i_s_tdata);
    assign w_full     = w_valid[MAX_POINTS-1];
    assign o_s_tready = !r_drain;
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_acc  = o_m_tvalid && i_m_tready;

    // Commands to the chain: insert on an accepted request with room left,
    // shift when the head result is taken.
    assign w_ctrl.load  = w_in_acc && !w_full;
    assign w_ctrl.shift = w_out_acc;

    // The chain of cells, head at index 0.
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        t_point w_prev_point;
        logic   w_prev_gt;
        logic   w_prev_valid;
        t_point w_next_point;
        logic   w_next_valid;

        if (i == 0) begin : g_head
            assign w_prev_point = w_in_point;
            assign w_prev_gt    = 1'b0;
            assign w_prev_valid = 1'b0;
        end else begin : g_body
            assign w_prev_point = w_point[i-1];
            assign w_prev_gt    = w_gt[i-1];
            assign w_prev_valid = w_valid[i-1];
        end

        if (i == MAX_POINTS - 1) begin : g_tail
            assign w_next_point = w_in_point;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_point = w_point[i+1];
            assign w_next_valid = w_valid[i+1];
        end

        psyx_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_point      (w_in_point),
            .i_prev_gt    (w_prev_gt),
            .i_prev_point (w_prev_point),
            .i_prev_valid (w_prev_valid),
            .i_next_point (w_next_point),
            .i_next_valid (w_next_valid),
            .o_gt         (w_gt[i]),
            .o_point      (w_point[i]),
            .o_valid      (w_valid[i])
        );

        assign w_valid_vec[i] = w_valid[i];
    end

    // Load/drain control and the overflow flag of the current set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            if (w_in_acc && w_full) begin
                r_ovf <= 1'b1;
            end
            if (w_in_acc && i_s_tlast) begin
                r_drain <= 1'b1;
            end
            if (w_out_acc && o_m_tlast) begin
                r_drain <= 1'b0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // Results come straight from the head cell register.
    assign o_m_tvalid = r_drain;
    assign o_m_tdata  = w_point[0];
    assign o_m_tlast  = !w_valid[1];
    assign o_m_tuser  = r_ovf;

    // Occupied cells always form an unbroken run from the head.
    `ASSERT_ALWAYS(a_valid_prefix,
        ((w_valid_vec >> 1) & ~w_valid_vec) == '0,
        "cell chain has a gap in its occupied cells")

    // A result is only offered while the head cell holds a point.
    `ASSERT_IMPLIES(a_head_valid, o_m_tvalid, w_valid[0],
        "result offered from an empty head cell")

    // The overflow flag is only raised by a request that found the chain full.
    `ASSERT_IMPLIES(a_ovf_cause, $rose(r_ovf), $past(w_in_acc && w_full),
        "overflow raised without a dropped point")

endmodule

/* test/point_sort_checker.sv */
// ----------------------------------------------------------------------------
// point_sort_checker
// Watches both streams of the point sorter. Every accepted input point is
// inserted into a local sorted copy of the current set. A point flagged
// final releases the whole set as the expected sorted results. Each accepted
// result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module point_sort_checker
    import psyx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input point stream, as seen at the block.
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [2*COORD_W-1:0] i_s_tdata,   // [19:0] point_x, [39:20] point_y
    input  logic                 i_s_tlast,   // final_point
    // Sorted result stream, as seen at the block.
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [2*COORD_W-1:0] i_m_tdata,   // [19:0] sorted_x, [39:20] sorted_y
    input  logic                 i_m_tlast,   // last_out
    input  logic                 i_m_tuser,   // overflowed
    output int                   o_mismatch_count,
    output int                   o_results_pending
);

    typedef struct packed {
        t_point pt;
        logic   last;
        logic   overflowed;
    } t_sorted_result;

    // Local copy of the set being collected, always kept in sorted order.
    t_point         held_points [MAX_POINTS];
    int             held_count;
    logic           dropped_any;
    t_sorted_result results_due [$];
    int             mismatches;

    // True when point a has to come out strictly ahead of point b.
    function automatic logic goes_first(input t_point a, input t_point b);
        if ($signed(a.y) != $signed(b.y)) begin
            return $signed(a.y) < $signed(b.y);
        end
        return $signed(a.x) < $signed(b.x);
    endfunction

    // Inserts one point into its sorted slot, or drops it if the set is full.
    task automatic insert_held_point(input t_point p);
        int slot;
        if (held_count >= MAX_POINTS) begin
            dropped_any = 1'b1;
            return;
        end
        slot = held_count;
        while (slot > 0 && goes_first(p, held_points[slot-1])) begin
            held_points[slot] = held_points[slot-1];
            slot--;
        end
        held_points[slot] = p;
        held_count++;
    endtask

    // Moves the whole sorted set into the expected results and starts afresh.
    task automatic release_sorted_set();
        t_sorted_result r;
        for (int k = 0; k < held_count; k++) begin
            r.pt         = held_points[k];
            r.last       = (k == held_count - 1);
            r.overflowed = dropped_any;
            results_due  = {results_due, r};
        end
        held_count  = 0;
        dropped_any = 1'b0;
    endtask

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Compares one accepted result against the oldest expected result.
    task automatic check_sorted_result();
        t_sorted_result want;
        logic signed [COORD_W-1:0] got_x;
        logic signed [COORD_W-1:0] got_y;
        got_x = i_m_tdata[COORD_W-1:0];
        got_y = i_m_tdata[2*COORD_W-1:COORD_W];
        if (results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result x=%0d y=%0d", got_x, got_y));
            return;
        end
        want = results_due.pop_front();
        if (got_x != want.pt.x) begin
            report_mismatch($sformatf("sorted_x got %0d, want %0d", got_x,
                                      $signed(want.pt.x)));
        end
        if (got_y != want.pt.y) begin
            report_mismatch($sformatf("sorted_y got %0d, want %0d", got_y,
                                      $signed(want.pt.y)));
        end
        if (i_m_tlast != want.last) begin
            report_mismatch($sformatf("last_out got %0b, want %0b", i_m_tlast, want.last));
        end
        if (i_m_tuser != want.overflowed) begin
            report_mismatch($sformatf("overflowed got %0b, want %0b", i_m_tuser,
                                      want.overflowed));
        end
    endtask

    // Sample both channels at each rising edge; results first, then requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count  = 0;
            dropped_any = 1'b0;
            mismatches  = 0;
            results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_sorted_result();
            end
            if (i_s_tvalid && i_s_tready) begin
                insert_held_point(t_point'({i_s_tdata[2*COORD_W-1:COORD_W],
                                            i_s_tdata[COORD_W-1:0]}));
                if (i_s_tlast) begin
                    release_sorted_set();
                end
            end
        end
        o_mismatch_count  <= mismatches;
        o_results_pending <= results_due.size();
    end

endmodule

/* test/tb_point_sort_by_y_then_x_core.sv */
// ----------------------------------------------------------------------------
// tb_point_sort_by_y_then_x_core
// Drives point sets into the sorter, from single points to one that fills
// the store and overflows, with random pauses on both streams. The checker beside
// the block predicts and compares every sorted result; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_point_sort_by_y_then_x_core;
    import psyx_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [2*COORD_W-1:0] i_s_tdata = '0;   // [19:0] point_x, [39:20] point_y
    logic                 i_s_tlast = 1'b0; // final_point
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b1;
    logic [2*COORD_W-1:0] o_m_tdata;        // [19:0] sorted_x, [39:20] sorted_y
    logic                 o_m_tlast;        // last_out
    logic                 o_m_tuser;        // overflowed

    int   mismatch_count;
    int   results_pending;
    int   cycle_count = 0;
    int   points_sent = 0;
    int   sink_hold = 0;
    logic quiet_phase = 1'b0;

    point_sort_by_y_then_x_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    point_sort_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_s_tlast         (i_s_tlast),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tlast         (o_m_tlast),
        .i_m_tuser         (o_m_tuser),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    always #5 i_clk = ~i_clk;

    // Give up if the run does not finish in time.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: ready drops in random bursts; none starts in the quiet phase.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            i_m_tready <= 1'b0;
        end else if (i_rst_n && !quiet_phase && $urandom_range(0, 9) == 0) begin
            sink_hold = $urandom_range(1, 15) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Picks a coordinate: full range, a narrow band that makes ties, or an extreme.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic [31:0] r;
        int          band;
        r    = $urandom;
        band = int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 3))
            0: return band[COORD_W-1:0];
            1: begin
                case (r[1:0])
                    2'd0:    return COORD_MIN;
                    2'd1:    return COORD_MAX;
                    2'd2:    return '0;
                    default: return '1;
                endcase
            end
            default: return r[COORD_W-1:0];
        endcase
    endfunction

    // Offers one point and holds it until the block accepts it.
    task automatic send_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic fin);
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {py, px};
        i_s_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        points_sent++;
    endtask

    // Sends a set of random points, the last one flagged final.
    task automatic send_set(input int n);
        for (int k = 0; k < n; k++) begin
            send_point(pick_coord(), pick_coord(), k == n - 1);
        end
    endtask

    // Mostly small sets, now and then a medium one.
    task automatic send_random_sets(input int until_points);
        while (points_sent < until_points) begin
            if ($urandom_range(0, 7) == 0) begin
                send_set($urandom_range(9, 20));
            end else begin
                send_set($urandom_range(1, 8));
            end
        end
    endtask

    // Waits until every expected result has come out.
    task automatic wait_drained();
        do @(posedge i_clk); while (results_pending != 0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-point set holding the opposite extremes.
        send_point(COORD_MAX, COORD_MIN, 1'b1);

        // Extremes, ties on y, a duplicate and the signed boundaries.
        send_point('0, '0, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point('1, '1, 1'b0);
        send_point(20'sd5, '1, 1'b0);
        send_point(-20'sd5, '1, 1'b0);
        send_point(20'sd5, '1, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(20'sd1, '0, 1'b1);

        // Final point sorts ahead of the one before it.
        send_point(20'sd100, 20'sd7, 1'b0);
        send_point(-20'sd100, 20'sd7, 1'b1);

        // Random part.
        send_random_sets(25);

        // The store fills up and the last two points, the final one included,
        // are dropped; then the sender holds off until the set has drained.
        send_set(MAX_POINTS + 2);
        i_s_tvalid <= 1'b0;
        wait_drained();

        send_random_sets(105);

        // Closing stretch with no pauses on either side.
        quiet_phase <= 1'b1;
        send_random_sets(120);

        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && results_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
